### hdl/stu_pkg.sv
// Shared types, constants and scanning functions of the source character tokeniser.
// Used by every module of the tokeniser; depends on nothing else.
package stu_pkg;

  // field widths
  localparam int ROW_BITS = 16;
  localparam int COL_BITS = 16;
  localparam int ID_BITS  = 16;
  localparam int CH_BITS  = 8;
  localparam int KIND_BITS = 2;

  localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};
  localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};
  localparam logic [ID_BITS-1:0]  ID_MAX  = {ID_BITS{1'b1}};

  // stream payload widths
  localparam int IN_DATA_BITS  = 8;
  localparam int IN_USER_BITS  = 1;
  localparam int OUT_FIELD_BITS = CH_BITS + ID_BITS + ROW_BITS + COL_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int TAB_BITS      = 5;
  localparam logic [TAB_BITS-1:0] TAB_RESET = 5'd4;
  localparam logic REG_TAB_WIDTH = 1'b0;  // word index, paddr[2]

  // request queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;
  localparam int MAX_RES     = 3;

  // result kinds
  localparam logic [KIND_BITS-1:0] KIND_WORD_CHAR = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_WORD_END  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SYMBOL    = 2'd2;

  // characters with a meaning of their own
  localparam logic [CH_BITS-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_BITS-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_BITS-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [CH_BITS-1:0]   ch;
    logic [ID_BITS-1:0]   id;
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
  } res_t;

  // all results of one input item
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
  } bundle_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [COL_BITS-1:0] wsc;
    logic                wopen;
    logic [ID_BITS-1:0]  tok;
  } scan_st_t;

  // state after one scanned character and the up to two results it gives
  typedef struct packed {
    scan_st_t       st;
    res_t [1:0]     res;
    logic [1:0]     n;
  } scan_out_t;

  function automatic logic is_delim(logic [CH_BITS-1:0] c);
    logic d;
    case (c)
      8'h20, 8'h0A, 8'h09, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3E,
      8'h3C, 8'h3D, 8'h3B, 8'h2C, 8'h28, 8'h29, 8'h7B, 8'h7D: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [ROW_BITS-1:0] sat_row(logic [ROW_BITS-1:0] v);
    return (v == ROW_MAX) ? ROW_MAX : v + 1'b1;
  endfunction

  function automatic logic [COL_BITS-1:0] sat_col(logic [COL_BITS-1:0] v);
    return (v == COL_MAX) ? COL_MAX : v + 1'b1;
  endfunction

  function automatic logic [ID_BITS-1:0] sat_id(logic [ID_BITS-1:0] v);
    return (v == ID_MAX) ? ID_MAX : v + 1'b1;
  endfunction

  function automatic logic [COL_BITS-1:0] sat_col_tab(logic [COL_BITS-1:0] v,
                                                      logic [TAB_BITS-1:0] tab);
    logic [COL_BITS:0] s;
    s = {1'b0, v} + (COL_BITS+1)'(tab);
    return (s >= {1'b0, COL_MAX}) ? COL_MAX : s[COL_BITS-1:0];
  endfunction

  // close the open word, if any
  function automatic scan_out_t flush_word(scan_st_t st);
    scan_out_t o;
    o = '0;
    o.st = st;
    if (st.wopen) begin
      o.st.tok = sat_id(st.tok);
      o.res[0].kind = KIND_WORD_END;
      o.res[0].ch   = '0;
      o.res[0].id   = o.st.tok;
      o.res[0].row  = st.row;
      o.res[0].col  = st.wsc;
      o.n = 2'd1;
      o.st.wopen = 1'b0;
    end
    return o;
  endfunction

  // scan one character in normal mode
  function automatic scan_out_t scan_char(scan_st_t st, logic [CH_BITS-1:0] c,
                                          logic [TAB_BITS-1:0] tab);
    scan_out_t o;
    if (is_delim(c)) begin
      o = flush_word(st);
      if (c != CH_SPACE && c != CH_NL && c != CH_TAB) begin
        o.st.tok = sat_id(o.st.tok);
        o.res[o.n[0]].kind = KIND_SYMBOL;
        o.res[o.n[0]].ch   = c;
        o.res[o.n[0]].id   = o.st.tok;
        o.res[o.n[0]].row  = o.st.row;
        o.res[o.n[0]].col  = o.st.col;
        o.n = o.n + 2'd1;
      end
      if (c == CH_NL) begin
        o.st.row = sat_row(o.st.row);
        o.st.col = '0;
      end else if (c == CH_TAB) begin
        o.st.col = sat_col_tab(o.st.col, tab);
      end else begin
        o.st.col = sat_col(o.st.col);
      end
      o.st.wsc = o.st.col;
    end else begin
      o = '0;
      o.st = st;
      o.st.wopen = 1'b1;
      o.res[0].kind = KIND_WORD_CHAR;
      o.res[0].ch   = c;
      o.res[0].id   = '0;
      o.res[0].row  = st.row;
      o.res[0].col  = st.col;
      o.n = 2'd1;
      o.st.col = sat_col(st.col);
    end
    return o;
  endfunction

  // append the results of one scan step to a bundle
  function automatic bundle_t append(bundle_t b, scan_out_t so);
    bundle_t r;
    r = b;
    for (int j = 0; j < 2; j++) begin
      if (so.n > 2'(j) && r.cnt < 2'(MAX_RES)) begin
        r.res[r.cnt] = so.res[j];
        r.cnt = r.cnt + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

### hdl/stu_front.sv
// Front end of the tokeniser: accepts characters, runs the comment and word scanner
// and hands the results of each character to the queue as one bundle. Uses stu_pkg.
module stu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [stu_pkg::CH_BITS-1:0]   char_in,
  input  logic                          end_of_input,
  input  logic [stu_pkg::TAB_BITS-1:0]  tab_width,
  output logic                          push,
  output stu_pkg::bundle_t              bundle
);
  import stu_pkg::*;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_STAR   = 3'd4;

  logic [2:0] mode_r, mode_nxt;
  scan_st_t   st_r, st_nxt;
  scan_out_t  s_one, s_slash, s_after, f_slash, f_plain;
  bundle_t    bnd;

  // scanner steps for every path a character may take
  always_comb begin
    s_one   = scan_char(st_r, char_in, tab_width);
    s_slash = scan_char(st_r, CH_SLASH, tab_width);
    s_after = scan_char(s_slash.st, char_in, tab_width);
    f_slash = flush_word(s_slash.st);
    f_plain = flush_word(st_r);
  end

  // choose the path by scan mode
  always_comb begin
    mode_nxt = mode_r;
    st_nxt   = st_r;
    bnd      = '0;
    if (end_of_input) begin
      mode_nxt = MODE_NORMAL;
      if (mode_r == MODE_SLASH) begin
        bnd    = append(append(bnd, s_slash), f_slash);
        st_nxt = f_slash.st;
      end else begin
        bnd    = append(bnd, f_plain);
        st_nxt = f_plain.st;
      end
    end else begin
      case (mode_r)
        MODE_SLASH: begin
          if (char_in == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (char_in == CH_STAR) begin
            mode_nxt   = MODE_BLOCK;
            st_nxt.col = sat_col(st_r.col);
          end else begin
            mode_nxt = MODE_NORMAL;
            bnd      = append(append(bnd, s_slash), s_after);
            st_nxt   = s_after.st;
          end
        end
        MODE_LINE: begin
          if (char_in == CH_NL) begin
            mode_nxt = MODE_NORMAL;
            bnd      = append(bnd, s_one);
            st_nxt   = s_one.st;
          end
        end
        MODE_BLOCK: begin
          if (char_in == CH_STAR) begin
            mode_nxt = MODE_STAR;
          end else if (char_in == CH_NL) begin
            st_nxt.row = sat_row(st_r.row);
            st_nxt.col = '0;
          end
        end
        MODE_STAR: begin
          if (char_in == CH_SLASH) begin
            mode_nxt = MODE_NORMAL;
          end else if (char_in != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
            if (char_in == CH_NL) begin
              st_nxt.row = sat_row(st_r.row);
              st_nxt.col = '0;
            end
          end
        end
        default: begin
          if (char_in == CH_SLASH) begin
            mode_nxt = MODE_SLASH;
          end else begin
            mode_nxt = MODE_NORMAL;
            bnd      = append(bnd, s_one);
            st_nxt   = s_one.st;
          end
        end
      endcase
    end
  end

  // advance scanner state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      st_r   <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      st_r   <= st_nxt;
    end
  end

  // drop characters that give no result
  assign push   = in_fire && (bnd.cnt != 2'd0);
  assign bundle = bnd;

endmodule

### hdl/stu_queue.sv
// Short bundle queue between the scanner front end and the result serialiser.
// Register based, first in first out. Uses stu_pkg.
module stu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stu_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output stu_pkg::bundle_t head
);
  import stu_pkg::*;

  bundle_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full       = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // move pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store the incoming bundle
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/stu_back.sv
// Back end of the tokeniser: takes bundles from the queue and presents their results
// one per cycle while out_tready is high, marking each bundle's last. Uses stu_pkg.
module stu_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                head_valid,
  input  stu_pkg::bundle_t                    head,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stu_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic [stu_pkg::KIND_BITS-1:0]       out_tuser,
  output logic                                out_tlast
);
  import stu_pkg::*;

  bundle_t    cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic       last;
  logic       load;
  res_t       sel;

  assign sel  = cur_r.res[idx_r];
  assign last = (idx_r == cur_r.cnt - 2'd1);
  assign load = !valid_r || (out_tready && last);
  assign pop  = load && head_valid;

  // step through the bundle, fetch the next one after its last result
  always_comb begin
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      cur_nxt   = head;
      idx_nxt   = 2'd0;
      valid_nxt = head_valid;
    end else if (out_tready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // hold the bundle being sent
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_DATA_BITS'({sel.col, sel.row, sel.id, sel.ch});
  assign out_tuser  = sel.kind;
  assign out_tlast  = last;

endmodule

### hdl/source_char_tokenizer_unit.sv
// Source character tokeniser: one character accepted per cycle while the bundle queue
// has room; results leave one per cycle while out_tready is high, and the serialiser,
// which sends the results of each character in turn, sets the sustained rate. The first
// result is registered in the queue and then in the serialiser before it is offered.
// Synchronous active-low reset returns the scanner to normal mode with row, column and
// token count at zero, empties the queue and sets the tab width to 4. Uses stu_pkg.
module source_char_tokenizer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [stu_pkg::IN_DATA_BITS-1:0]     in_tdata,   // [7:0] char_in
  input  logic [stu_pkg::IN_USER_BITS-1:0]     in_tuser,   // [0] end_of_input
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [stu_pkg::OUT_DATA_BITS-1:0]    out_tdata,  // char_out, token_number,
                                                           // row_out, col_out
  output logic [stu_pkg::KIND_BITS-1:0]        out_tuser,  // [1:0] kind
  output logic                                 out_tlast,  // last_of_run
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [stu_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [stu_pkg::CFG_DATA_BITS-1:0]    cfg_pwdata,
  output logic [stu_pkg::CFG_DATA_BITS-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);
  import stu_pkg::*;

  logic [TAB_BITS-1:0] tab_r;
  logic                cfg_wr;
  logic                in_fire;
  logic                push, full, pop, head_valid;
  bundle_t             push_data, head;

  // register write on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_r <= TAB_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TAB_WIDTH) begin
      tab_r <= cfg_pwdata[TAB_BITS-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TAB_WIDTH) ?
                      CFG_DATA_BITS'(tab_r) : '0;

  // accept while the queue has room
  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  stu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .char_in      (in_tdata[CH_BITS-1:0]),
    .end_of_input (in_tuser[0]),
    .tab_width    (tab_r),
    .push         (push),
    .bundle       (push_data)
  );

  stu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  stu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
